FILE: rtl/core/lspd_pkg.sv
// Package for the scan packet range decoder: word types, result kinds,
// byte codes and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lspd_pkg;

    localparam int LINE_DATA_CHARS_DEF = 64;
    localparam int MAX_STEPS_DEF       = 1081;

    localparam int BYTE_W  = 8;
    localparam int STEP_W  = 11;
    localparam int DIST_W  = 18;
    localparam int KIND_W  = 2;
    localparam int SIX_W   = 6;

    localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 11'd1081;

    localparam logic [BYTE_W-1:0] BYTE_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h30;

    localparam logic [KIND_W-1:0] RK_RANGE      = 2'd0;
    localparam logic [KIND_W-1:0] RK_BAD_STATUS = 2'd1;
    localparam logic [KIND_W-1:0] RK_CHECKSUM   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic              packet_start;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [STEP_W-1:0] step_index;
        logic [DIST_W-1:0] distance_mm;
        logic              scan_last;
    } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/core/lidar_scan_packet_decoder_unit.sv
// Scan packet range decoder top level: byte parser, step count register
// and two-entry output buffer. Depends on lspd_pkg.
//
// Result words are registered into the output register, or into the skid word
// while out_stall holds it. Throughput: one byte per cycle while in_stall is
// low; the parser state updates in a single pass. in_stall rises only while
// both output registers hold words. Reset clears the parser to idle, empties
// the output buffer and loads steps_reg with 1081, or MAX_STEPS if smaller.
`timescale 1ns / 1ps
`default_nettype none

module lidar_scan_packet_decoder_unit
#(
    parameter int LINE_DATA_CHARS = lspd_pkg::LINE_DATA_CHARS_DEF,
    parameter int MAX_STEPS       = lspd_pkg::MAX_STEPS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire lspd_pkg::in_word_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output lspd_pkg::out_word_t                out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lspd_pkg::STEP_W-1:0]   cfg_data
);
    import lspd_pkg::*;

    localparam int LPOS_W = $clog2(LINE_DATA_CHARS + 2);
    localparam logic [LPOS_W-1:0] LPOS_DATA = LPOS_W'(LINE_DATA_CHARS);
    localparam logic [LPOS_W-1:0] LPOS_CSUM = LPOS_W'(LINE_DATA_CHARS + 1);
    localparam logic [STEP_W-1:0] MAX_STEPS_V = STEP_W'(MAX_STEPS);
    localparam logic [STEP_W-1:0] STEPS_RESET =
        (STEP_COUNT_RESET > MAX_STEPS_V) ? MAX_STEPS_V : STEP_COUNT_RESET;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ECHO   = 3'd1;
    localparam logic [2:0] PH_STATUS = 3'd2;
    localparam logic [2:0] PH_STAMP  = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [STEP_W-1:0]    steps_reg;
    logic [2:0]           phase_reg,     phase_next;
    logic [1:0]           stat_pos_reg,  stat_pos_next;
    logic [LPOS_W-1:0]    line_pos_reg,  line_pos_next;
    logic [SIX_W-1:0]     line_sum_reg,  line_sum_next;
    logic [2*SIX_W-1:0]   trip_acc_reg,  trip_acc_next;
    logic [1:0]           trip_pos_reg,  trip_pos_next;
    logic [STEP_W-1:0]    val_cnt_reg,   val_cnt_next;

    logic                 out_valid_reg;
    out_word_t            out_word_reg;
    logic                 skid_valid_reg;
    out_word_t            skid_word_reg;

    logic                 accept;
    logic                 res_valid;
    out_word_t            res_word;
    logic [BYTE_W-1:0]    b;
    logic [SIX_W-1:0]     six;
    logic [BYTE_W-1:0]    csum_expect;
    logic [STEP_W:0]      idx_plus;
    logic                 is_last;
    logic [STEP_W-1:0]    cfg_clamped;
    logic                 out_free;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign b           = in_data.packet_byte;
    assign six         = b[SIX_W-1:0] - BYTE_ZERO[SIX_W-1:0];
    assign csum_expect = {2'b00, line_sum_reg} + BYTE_ZERO;
    assign idx_plus    = {1'b0, val_cnt_reg} + (STEP_W+1)'(1);
    assign is_last     = idx_plus >= {1'b0, steps_reg};

    always_comb
    begin
        if (cfg_data == '0)
            cfg_clamped = STEP_W'(1);
        else if (cfg_data > MAX_STEPS_V)
            cfg_clamped = MAX_STEPS_V;
        else
            cfg_clamped = cfg_data;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        stat_pos_next = stat_pos_reg;
        line_pos_next = line_pos_reg;
        line_sum_next = line_sum_reg;
        trip_acc_next = trip_acc_reg;
        trip_pos_next = trip_pos_reg;
        val_cnt_next  = val_cnt_reg;
        res_valid     = 1'b0;
        res_word      = '0;

        if (in_data.packet_start)
        begin
            phase_next    = PH_ECHO;
            stat_pos_next = '0;
            line_pos_next = '0;
            line_sum_next = '0;
            trip_acc_next = '0;
            trip_pos_next = '0;
            val_cnt_next  = '0;
        end

        unique case (phase_next)
            PH_ECHO:
            begin
                if (b == BYTE_LF)
                    phase_next = PH_STATUS;
            end
            PH_STATUS:
            begin
                if (stat_pos_next < 2'd2)
                begin
                    if (b != BYTE_NINE)
                    begin
                        phase_next           = PH_DONE;
                        res_valid            = 1'b1;
                        res_word.result_kind = RK_BAD_STATUS;
                        res_word.scan_last   = 1'b1;
                    end
                    else
                    begin
                        stat_pos_next = stat_pos_next + 2'd1;
                    end
                end
                else if (b == BYTE_LF)
                begin
                    phase_next = PH_STAMP;
                end
            end
            PH_STAMP:
            begin
                if (b == BYTE_LF)
                begin
                    phase_next    = PH_DATA;
                    line_pos_next = '0;
                    line_sum_next = '0;
                end
            end
            PH_DATA:
            begin
                if (line_pos_reg < LPOS_DATA)
                begin
                    line_sum_next = line_sum_reg + b[SIX_W-1:0];
                    line_pos_next = line_pos_reg + LPOS_W'(1);
                    if (trip_pos_reg < 2'd2)
                    begin
                        trip_acc_next = {trip_acc_reg[SIX_W-1:0], six};
                        trip_pos_next = trip_pos_reg + 2'd1;
                    end
                    else
                    begin
                        trip_acc_next        = '0;
                        trip_pos_next        = '0;
                        val_cnt_next         = val_cnt_reg + STEP_W'(1);
                        res_valid            = 1'b1;
                        res_word.result_kind = RK_RANGE;
                        res_word.step_index  = val_cnt_reg;
                        res_word.distance_mm = {trip_acc_reg, six};
                        res_word.scan_last   = is_last;
                        if (is_last)
                            phase_next = PH_DONE;
                    end
                end
                else if (line_pos_reg == LPOS_DATA)
                begin
                    if (csum_expect != b)
                    begin
                        phase_next           = PH_DONE;
                        res_valid            = 1'b1;
                        res_word.result_kind = RK_CHECKSUM;
                        res_word.scan_last   = 1'b1;
                    end
                    else
                    begin
                        line_pos_next = LPOS_CSUM;
                    end
                end
                else
                begin
                    line_pos_next = '0;
                    line_sum_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg    <= STEPS_RESET;
            phase_reg    <= PH_IDLE;
            stat_pos_reg <= '0;
            line_pos_reg <= '0;
            line_sum_reg <= '0;
            trip_acc_reg <= '0;
            trip_pos_reg <= '0;
            val_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                steps_reg <= cfg_clamped;
            if (accept)
            begin
                phase_reg    <= phase_next;
                stat_pos_reg <= stat_pos_next;
                line_pos_reg <= line_pos_next;
                line_sum_reg <= line_sum_next;
                trip_acc_reg <= trip_acc_next;
                trip_pos_reg <= trip_pos_next;
                val_cnt_reg  <= val_cnt_next;
            end
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= accept && res_valid;
        end
        else if (accept && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
                out_word_reg <= skid_word_reg;
        end
        else if (out_free)
        begin
            out_word_reg <= res_word;
        end
        else if (accept && res_valid)
        begin
            skid_word_reg <= res_word;
        end
    end

endmodule

`default_nettype wire
